// File: rtl/conv33_pkg.sv
// ============================================================================
// conv33_pkg: shared types and constants for the 3x3 same-size convolution
// Widths, kernel geometry, register map and the control groups passed
// between the top level, the window cells and the result queue.
// ============================================================================
package conv33_pkg;

    // geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int KERNEL_ROWS = 3;
    localparam int KERNEL_COLS = 3;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);

    // dimension counters and the frame size registers
    localparam int DIM_W = 11;
    localparam int DP_W  = DIM_W + 1;
    localparam int W_CAP = (MAX_WIDTH < 2 ** DIM_W) ? MAX_WIDTH : 2 ** DIM_W - 1;
    localparam logic [DIM_W-1:0] ROW_LIMIT = '1;

    // data path
    localparam int PIXEL_W = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIXEL_W + COEF_W;
    localparam int PSUM_W  = PROD_W + 2;
    localparam int TOTAL_W = PSUM_W + 2;
    localparam int VALUE_W = 35;
    localparam int LINE_W  = 2 * PIXEL_W;

    // configuration port
    localparam int COEF_ROW_W = KERNEL_COLS * COEF_W;
    localparam int CFG_DATA_W = 64;
    localparam int PADDR_W    = 6;
    localparam int REG_IDX_W  = 3;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [PIXEL_W-1:0] pixel_t;
    typedef pixel_t [KERNEL_ROWS-1:0]  column_t;   // [0] top .. [KERNEL_ROWS-1] bottom
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PSUM_W-1:0]  psum_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [REG_IDX_W-1:0]      reg_index_t;

    // register map, index = byte address / 8
    localparam reg_index_t REG_FRAME_WIDTH  = reg_index_t'(0);
    localparam reg_index_t REG_FRAME_HEIGHT = reg_index_t'(1);
    localparam reg_index_t REG_COEF_TOP     = reg_index_t'(2);
    localparam reg_index_t REG_COEF_MIDDLE  = reg_index_t'(3);
    localparam reg_index_t REG_COEF_BOTTOM  = reg_index_t'(4);

    localparam logic [DIM_W-1:0]      FRAME_WIDTH_RESET  = DIM_W'(4);
    localparam logic [DIM_W-1:0]      FRAME_HEIGHT_RESET = DIM_W'(4);
    localparam logic [COEF_ROW_W-1:0] COEF_TOP_RESET     = '0;
    localparam logic [COEF_ROW_W-1:0] COEF_MIDDLE_RESET  = COEF_ROW_W'(64'h4000_0000);
    localparam logic [COEF_ROW_W-1:0] COEF_BOTTOM_RESET  = '0;

    // which border taps survive for one output position
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } keep_t;

    // per-cell control for one cycle
    typedef struct packed {
        logic shift_en;
        logic mul_en;
        logic sum_en;
        logic keep_top;
        logic keep_bottom;
        logic keep_col;
    } cell_ctrl_t;

    typedef struct packed {
        logic   last;
        value_t value;
    } result_t;

endpackage

// File: rtl/conv33_ram.sv
// ============================================================================
// conv33_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module conv33_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/conv33_cell.sv
// ============================================================================
// conv33_cell: one column of the 3x3 window
// Holds one window column, hands it to the left neighbor on every shift,
// multiplies it by its coefficient column and reduces to a partial sum.
// ============================================================================
module conv33_cell (
    input  logic                   clk,
    input  conv33_pkg::cell_ctrl_t ctrl,
    input  conv33_pkg::column_t    col_in,
    input  conv33_pkg::column_t    coef,
    output conv33_pkg::column_t    col_out,
    output conv33_pkg::psum_t      psum
);
    import conv33_pkg::*;

    column_t                px_reg;
    prod_t                  prod_reg  [KERNEL_ROWS];
    prod_t                  prod_next [KERNEL_ROWS];
    logic [KERNEL_ROWS-1:0] keep_row;
    psum_t                  psum_reg;
    psum_t                  psum_next;

    always_comb
    begin
        for (int r = 0; r < KERNEL_ROWS; r++)
        begin
            keep_row[r] = ctrl.keep_col;
            if (r == 0 && !ctrl.keep_top)
            begin
                keep_row[r] = 1'b0;
            end
            if (r == KERNEL_ROWS - 1 && !ctrl.keep_bottom)
            begin
                keep_row[r] = 1'b0;
            end
            // drop taps that fall outside the frame
            if (keep_row[r])
            begin
                prod_next[r] = $signed(px_reg[r]) * $signed(coef[r]);
            end
            else
            begin
                prod_next[r] = '0;
            end
        end
    end

    always_comb
    begin
        psum_next = '0;
        for (int r = 0; r < KERNEL_ROWS; r++)
        begin
            psum_next = psum_next + PSUM_W'(prod_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            px_reg <= col_in;
        end
        if (ctrl.mul_en)
        begin
            for (int r = 0; r < KERNEL_ROWS; r++)
            begin
                prod_reg[r] <= prod_next[r];
            end
        end
        if (ctrl.sum_en)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = px_reg;
    assign psum    = psum_reg;

endmodule

// File: rtl/conv33_fifo.sv
// ============================================================================
// conv33_fifo: result queue
// Small register queue between the pipeline and the output channel.
// ============================================================================
module conv33_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  conv33_pkg::result_t push_item,
    input  logic                pop,
    output logic                not_empty,
    output conv33_pkg::result_t head
);
    import conv33_pkg::*;

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue written while full");

endmodule

// File: rtl/conv2d_same_3x3_core.sv
// ============================================================================
// conv2d_same_3x3_core: streaming 3x3 zero-padded same-size convolution
// Raster-order signed pixels in, raster-order Q1.14-weighted 3x3 sums out,
// built as a line-buffer RAM feeding a chain of three window column cells.
// ============================================================================
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  input   | in_valid, in_ready, operation, pixel             | in
//  output  | out_valid, out_ready, conv_value, last_of_frame  | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata,    | in / out
//          | pready (registers at byte address 8*index)       |
//
//  One item per cycle while in_ready is high. A result passes through the
//  line RAM read, window shift, multiply, column sum and final sum before
//  it reaches the output queue. in_ready depends only on the count of results
//  owed but not yet taken; it drops once that count reaches the queue depth
//  of eight, so a stalled output never loses a result. The pipeline itself
//  never stalls. Reset clears counters, handshake state and registers; the
//  line RAM needs no clearing.
//
module conv2d_same_3x3_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  conv33_pkg::pixel_t                    pixel,
    // result items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output conv33_pkg::value_t                    conv_value,
    output logic                                  last_of_frame,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [conv33_pkg::PADDR_W-1:0]        paddr,
    input  logic [conv33_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [conv33_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                  pready
);
    import conv33_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]      frame_width_reg;
    logic [DIM_W-1:0]      frame_height_reg;
    logic [COEF_ROW_W-1:0] coef_top_reg;
    logic [COEF_ROW_W-1:0] coef_middle_reg;
    logic [COEF_ROW_W-1:0] coef_bottom_reg;
    reg_index_t            cfg_index;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            coef_top_reg     <= COEF_TOP_RESET;
            coef_middle_reg  <= COEF_MIDDLE_RESET;
            coef_bottom_reg  <= COEF_BOTTOM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                REG_COEF_TOP:     coef_top_reg     <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_MIDDLE:  coef_middle_reg  <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_BOTTOM:  coef_bottom_reg  <= pwdata[COEF_ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_reg);
            REG_COEF_TOP:     prdata = CFG_DATA_W'(coef_top_reg);
            REG_COEF_MIDDLE:  prdata = CFG_DATA_W'(coef_middle_reg);
            REG_COEF_BOTTOM:  prdata = CFG_DATA_W'(coef_bottom_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // position counters and per-item decisions, at acceptance
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   in_col_reg,  in_col_next;
    logic [DIM_W-1:0]   in_row_reg,  in_row_next;
    logic [DIM_W-1:0]   out_col_reg, out_col_next;
    logic [DIM_W-1:0]   out_row_reg, out_row_next;
    logic [FIFO_CNT_W-1:0] pending_reg, pending_next;

    logic [DP_W-1:0]    w_eff, h_eff;
    logic [DP_W-1:0]    ci, ci_inc, oc, oc_inc, orow_inc;
    logic               col_wrap, ocol_wrap, orow_end;
    logic               item_primed, item_last;
    keep_t              item_keep;
    pixel_t             item_pixel;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_accept, out_accept;

    assign in_ready   = (pending_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;

    always_comb
    begin
        // clamp geometry: zero counts as one, width saturates at the line length
        if (frame_width_reg == '0)
        begin
            w_eff = DP_W'(1);
        end
        else if ({1'b0, frame_width_reg} > DP_W'(W_CAP))
        begin
            w_eff = DP_W'(W_CAP);
        end
        else
        begin
            w_eff = {1'b0, frame_width_reg};
        end
        h_eff = (frame_height_reg == '0) ? DP_W'(1) : {1'b0, frame_height_reg};

        // column positions at or past the width wrap to zero
        ci       = ({1'b0, in_col_reg} < w_eff) ? {1'b0, in_col_reg} : '0;
        ci_inc   = ci + DP_W'(1);
        col_wrap = (ci_inc >= w_eff);
        oc       = ({1'b0, out_col_reg} < w_eff) ? {1'b0, out_col_reg} : '0;
        oc_inc   = oc + DP_W'(1);
        ocol_wrap = (oc_inc >= w_eff);
        orow_inc = {1'b0, out_row_reg} + DP_W'(1);
        orow_end = (orow_inc >= h_eff);

        item_primed = (in_row_reg >= DIM_W'(2)) ||
                      (in_row_reg == DIM_W'(1) && ci != '0);
        item_last   = orow_end && ocol_wrap;

        item_keep.top    = (out_row_reg != '0);
        item_keep.bottom = !orow_end;
        item_keep.left   = (oc != '0);
        item_keep.right  = !ocol_wrap;

        item_pixel = operation ? pixel_t'(0) : pixel;
        rd_addr    = ADDR_W'(ci);
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_accept)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != ROW_LIMIT)
                begin
                    in_row_next = in_row_reg + DIM_W'(1);
                end
            end
            else
            begin
                in_col_next = ci_inc[DIM_W-1:0];
            end

            if (item_primed)
            begin
                if (item_last)
                begin
                    // frame done: restart every position counter
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (ocol_wrap)
                begin
                    out_col_next = '0;
                    if (out_row_reg != ROW_LIMIT)
                    begin
                        out_row_next = out_row_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    out_col_next = oc_inc[DIM_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if ((in_accept && item_primed) && !out_accept)
        begin
            pending_next = pending_reg + FIFO_CNT_W'(1);
        end
        else if (out_accept && !(in_accept && item_primed))
        begin
            pending_next = pending_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line RAM data returns, RAM written back, window shifts
    // ------------------------------------------------------------------
    logic                s1_valid_reg, s1_res_reg, s1_last_reg, s1_fwd_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    pixel_t              s1_pix_reg;
    keep_t               s1_keep_reg;
    logic [LINE_W-1:0]   s1_fwd_data_reg;
    logic [LINE_W-1:0]   ram_rdata, rd_word, wr_word;
    pixel_t              rd_upper, rd_lower;
    logic                fwd_hit;
    column_t             new_col;

    // an item reading the entry that stage 1 writes this cycle takes the
    // written data instead of the stale RAM read
    assign fwd_hit = s1_valid_reg && (s1_addr_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s1_res_reg   <= in_accept && item_primed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg     <= rd_addr;
            s1_pix_reg      <= item_pixel;
            s1_keep_reg     <= item_keep;
            s1_last_reg     <= item_last;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= wr_word;
        end
    end

    conv33_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (wr_word),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rd_word  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        rd_upper = rd_word[LINE_W-1:PIXEL_W];
        rd_lower = rd_word[PIXEL_W-1:0];
        // advance each column by one row: lower line moves up, new pixel enters
        wr_word  = {rd_lower, s1_pix_reg};
        new_col  = '0;
        new_col[0]               = rd_upper;
        new_col[1]               = rd_lower;
        new_col[KERNEL_ROWS-1]   = s1_pix_reg;
    end

    // ------------------------------------------------------------------
    // stages 2..4: multiply, column sum, final sum
    // ------------------------------------------------------------------
    logic   s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic   s2_last_reg,  s3_last_reg,  s4_last_reg;
    keep_t  s2_keep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_keep_reg <= s1_keep_reg;
        s2_last_reg <= s1_last_reg;
        s3_last_reg <= s2_last_reg;
        s4_last_reg <= s3_last_reg;
    end

    // ------------------------------------------------------------------
    // window cell chain: the rightmost cell takes the new column, every
    // other cell takes its right neighbor's column
    // ------------------------------------------------------------------
    logic [COEF_ROW_W-1:0] coef_rows [KERNEL_ROWS];
    column_t               cell_coef [KERNEL_COLS];
    column_t               cell_in   [KERNEL_COLS];
    column_t               cell_out  [KERNEL_COLS];
    psum_t                 cell_psum [KERNEL_COLS];
    cell_ctrl_t            cell_ctrl [KERNEL_COLS];

    always_comb
    begin
        coef_rows[0]             = coef_top_reg;
        coef_rows[1]             = coef_middle_reg;
        coef_rows[KERNEL_ROWS-1] = coef_bottom_reg;
        for (int c = 0; c < KERNEL_COLS; c++)
        begin
            for (int r = 0; r < KERNEL_ROWS; r++)
            begin
                cell_coef[c][r] = coef_rows[r][COEF_W*c +: COEF_W];
            end
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < KERNEL_COLS; gc++)
        begin : g_cell
            if (gc == KERNEL_COLS - 1)
            begin : g_feed
                assign cell_in[gc] = new_col;
            end
            else
            begin : g_link
                assign cell_in[gc] = cell_out[gc+1];
            end

            assign cell_ctrl[gc].shift_en    = s1_valid_reg;
            assign cell_ctrl[gc].mul_en      = s2_valid_reg;
            assign cell_ctrl[gc].sum_en      = s3_valid_reg;
            assign cell_ctrl[gc].keep_top    = s2_keep_reg.top;
            assign cell_ctrl[gc].keep_bottom = s2_keep_reg.bottom;
            assign cell_ctrl[gc].keep_col    = (gc == 0)               ? s2_keep_reg.left  :
                                               (gc == KERNEL_COLS - 1) ? s2_keep_reg.right :
                                                                         1'b1;

            conv33_cell u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl[gc]),
                .col_in  (cell_in[gc]),
                .coef    (cell_coef[gc]),
                .col_out (cell_out[gc]),
                .psum    (cell_psum[gc])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // final sum and result queue
    // ------------------------------------------------------------------
    logic signed [TOTAL_W-1:0] total;
    result_t                   push_item;
    result_t                   head;

    always_comb
    begin
        total = '0;
        for (int c = 0; c < KERNEL_COLS; c++)
        begin
            total = total + TOTAL_W'(cell_psum[c]);
        end
        push_item.value = total[VALUE_W-1:0];
        push_item.last  = s4_last_reg;
    end

    conv33_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_valid_reg),
        .push_item (push_item),
        .pop       (out_accept),
        .not_empty (out_valid),
        .head      (head)
    );

    assign conv_value    = head.value;
    assign last_of_frame = head.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    ap_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("owed result count above queue depth");

    ap_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result shown that was never owed");

    ap_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && item_primed && item_last) |=>
            (in_col_reg == '0 && in_row_reg == '0 &&
             out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after final result of frame");

endmodule
